// ----- hdl/lfk_pkg.sv -----
// Shared types, constants and the quarter-wave sine table generator for the
// leg forward kinematics pipeline. No dependencies.
package lfk_pkg;

	localparam int LEG_COUNT    = 4;
	localparam int ANG_W        = 12;  // signed step angle, 2000-step circle
	localparam int SIN_W        = 18;  // signed sine value, up to 2^16
	localparam int QROM_DEPTH   = 501;
	localparam int P1_W         = 32;  // length * sine
	localparam int P2_W         = 50;  // length * sine * sine
	localparam int SUM_W        = 20;
	localparam int CIRCLE_STEPS = 2000;

	localparam logic [2:0] REG_HIP_LEN   = 3'd0;
	localparam logic [2:0] REG_THIGH_LEN = 3'd1;
	localparam logic [2:0] REG_SHIN_LEN  = 3'd2;
	localparam logic [2:0] REG_HIP_XY    = 3'd3;
	localparam logic [2:0] REG_HIP_Z     = 3'd4;
	localparam logic [2:0] REG_DIR_MASK  = 3'd5;

	typedef logic [16:0] qrom_t [0:QROM_DEPTH-1];

	typedef struct packed {
		logic [12:0]        hip_len;
		logic [12:0]        thigh_len;
		logic [12:0]        shin_len;
		logic [12:0]        hip_xy;
		logic signed [13:0] hip_z;
		logic [11:0]        dir_mask;
	} cfg_t;

	typedef struct packed {
		logic [1:0]               leg;
		logic signed [ANG_W-1:0]  toe;
		logic signed [ANG_W-1:0]  knee;
		logic signed [ANG_W-1:0]  yaw;
	} angles_t;

	typedef struct packed {
		logic [1:0]              leg;
		logic signed [SIN_W-1:0] cy;
		logic signed [SIN_W-1:0] sy;
		logic signed [SIN_W-1:0] cp;
		logic signed [SIN_W-1:0] sp;
		logic signed [SIN_W-1:0] ct;
		logic signed [SIN_W-1:0] st;
	} trig_t;

	typedef struct packed {
		logic [1:0]             leg;
		logic signed [P1_W-1:0] lh_cy;
		logic signed [P1_W-1:0] lh_sy;
		logic signed [P1_W-1:0] lt_sp;
		logic signed [P1_W-1:0] ls_st;
		logic signed [P2_W-1:0] fx;
		logic signed [P2_W-1:0] fy;
		logic signed [P2_W-1:0] tx;
		logic signed [P2_W-1:0] ty;
	} prod_t;

	// Q30 Taylor series sine, rounded half up to f fraction bits
	function automatic qrom_t build_qrom(int f);
		qrom_t rom;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		for (int k = 0; k < QROM_DEPTH; k++) begin
			x = (longint'(k) * 64'd3373259426 + 64'd500) / 1000;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
			if (sum < 0)
				sum = 0;
			if (sum > (longint'(1) << 30))
				sum = longint'(1) << 30;
			rom[k] = 17'((sum + (longint'(1) << (29 - f))) >>> (30 - f));
		end
		return rom;
	endfunction

	function automatic logic [15:0] sat16(logic signed [SUM_W-1:0] v);
		if (v > 20'sd32767)
			return 16'h7fff;
		if (v < -20'sd32768)
			return 16'h8000;
		return v[15:0];
	endfunction

endpackage

// ----- hdl/leg_forward_kinematics.sv -----
// Leg forward kinematics: top level with config registers and output stage.
// Depends on lfk_pkg, lfk_angle, lfk_trig, lfk_mult.
//
// One leg per transaction, one transaction per cycle while the master side
// does not stall: a five-stage pipeline (angle, table lookup, length
// multiply, projection multiply, round/sum/saturate) passes each result
// through these registers in order, and m_tvalid comes from the last. The
// whole pipeline advances together whenever the output register is empty or
// being taken, so a stall on the master side holds every stage in place.
// Config registers must be written only when the pipeline is empty.
module leg_forward_kinematics import lfk_pkg::*; #(
	parameter int SINE_FRAC_BITS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,  // toe_pulse, knee_pulse, yaw_pulse, 4'b0
	input  logic [1:0]   s_tuser,  // leg_index
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // knee_x,y,z, foot_x,y,z, toe_x,y,z
	output logic [1:0]   m_tuser   // leg_echo
);

	localparam int F = SINE_FRAC_BITS;
	localparam logic signed [P1_W-1:0] HALF1 = P1_W'(longint'(1) << (F - 1));
	localparam logic signed [P2_W-1:0] HALF2 = P2_W'(longint'(1) << (2 * F - 1));

	cfg_t    cfg_q;
	logic    en;
	logic    valid_s1, valid_s2, valid_s4;
	angles_t ang_s1;
	trig_t   trig_s2;
	prod_t   prod_s4;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hip_len   <= 13'd1162;
			cfg_q.thigh_len <= 13'd1894;
			cfg_q.shin_len  <= 13'd1510;
			cfg_q.hip_xy    <= 13'd1600;
			cfg_q.hip_z     <= -14'sd562;
			cfg_q.dir_mask  <= 12'hfff;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_HIP_LEN:   cfg_q.hip_len   <= pwdata[12:0];
				REG_THIGH_LEN: cfg_q.thigh_len <= pwdata[12:0];
				REG_SHIN_LEN:  cfg_q.shin_len  <= pwdata[12:0];
				REG_HIP_XY:    cfg_q.hip_xy    <= pwdata[12:0];
				REG_HIP_Z:     cfg_q.hip_z     <= $signed(pwdata[13:0]);
				REG_DIR_MASK:  cfg_q.dir_mask  <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HIP_LEN:   prdata = {19'd0, cfg_q.hip_len};
			REG_THIGH_LEN: prdata = {19'd0, cfg_q.thigh_len};
			REG_SHIN_LEN:  prdata = {19'd0, cfg_q.shin_len};
			REG_HIP_XY:    prdata = {19'd0, cfg_q.hip_xy};
			REG_HIP_Z:     prdata = {18'd0, cfg_q.hip_z};
			REG_DIR_MASK:  prdata = {20'd0, cfg_q.dir_mask};
			default:       prdata = 32'd0;
		endcase
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	lfk_angle u_angle (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.leg        (s_tuser),
		.toe_pulse  (s_tdata[11:0]),
		.knee_pulse (s_tdata[23:12]),
		.yaw_pulse  (s_tdata[35:24]),
		.cfg        (cfg_q),
		.valid_s1   (valid_s1),
		.ang_s1     (ang_s1)
	);

	lfk_trig #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_trig (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.ang_s1   (ang_s1),
		.valid_s2 (valid_s2),
		.trig_s2  (trig_s2)
	);

	lfk_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s2 (valid_s2),
		.trig_s2  (trig_s2),
		.cfg      (cfg_q),
		.valid_s4 (valid_s4),
		.prod_s4  (prod_s4)
	);

	// stage 5: round half up, accumulate, saturate
	logic signed [P1_W-1:0]  r_lh_cy, r_lh_sy, r_lt_sp, r_ls_st;
	logic signed [P2_W-1:0]  r_fx, r_fy, r_tx, r_ty;
	logic signed [SUM_W-1:0] h, hx, hy, kx, ky, kz, fx, fy, fz, tx, ty, tz;

	always_comb begin
		r_lh_cy = (prod_s4.lh_cy + HALF1) >>> F;
		r_lh_sy = (prod_s4.lh_sy + HALF1) >>> F;
		r_lt_sp = (prod_s4.lt_sp + HALF1) >>> F;
		r_ls_st = (prod_s4.ls_st + HALF1) >>> F;
		r_fx    = (prod_s4.fx + HALF2) >>> (2 * F);
		r_fy    = (prod_s4.fy + HALF2) >>> (2 * F);
		r_tx    = (prod_s4.tx + HALF2) >>> (2 * F);
		r_ty    = (prod_s4.ty + HALF2) >>> (2 * F);
		h  = $signed({7'd0, cfg_q.hip_xy});
		hx = prod_s4.leg[0] ? h : -h;   // left legs sit at negative x
		hy = prod_s4.leg[1] ? -h : h;   // rear legs sit at negative y
		kx = hx + SUM_W'(r_lh_cy);
		ky = hy + SUM_W'(r_lh_sy);
		kz = SUM_W'(cfg_q.hip_z);
		fx = kx + SUM_W'(r_fx);
		fy = ky + SUM_W'(r_fy);
		fz = kz + SUM_W'(r_lt_sp);
		tx = fx + SUM_W'(r_tx);
		ty = fy + SUM_W'(r_ty);
		tz = fz + SUM_W'(r_ls_st);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser <= prod_s4.leg;
			m_tdata <= {sat16(tz), sat16(ty), sat16(tx), sat16(fz), sat16(fy), sat16(fx),
				sat16(kz), sat16(ky), sat16(kx)};
		end
	end

	// input side only stalls when a finished result is held back
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output stall");

	// knee z is hip height if user keeps config stable with results in flight
	a_knee_z: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[47:32] == {{2{cfg_q.hip_z[13]}}, cfg_q.hip_z}))
		else $error("knee_z differs from hip height");

	// a stalled result keeps its leg tag and its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser) && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

// ----- hdl/lfk_angle.sv -----
// Stage 1: pulse clamp, pulse to step angle, direction sign, mounting yaw.
// Depends on lfk_pkg.
module lfk_angle import lfk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [1:0]  leg,
	input  logic [11:0] toe_pulse,
	input  logic [11:0] knee_pulse,
	input  logic [11:0] yaw_pulse,
	input  cfg_t        cfg,
	output logic        valid_s1,
	output angles_t     ang_s1
);

	logic [3:0]              base;
	logic signed [ANG_W-1:0] toe_a;
	logic signed [ANG_W-1:0] knee_a;
	logic signed [ANG_W-1:0] yaw_a;
	logic signed [ANG_W-1:0] mount;

	function automatic logic signed [ANG_W-1:0] to_steps(logic [11:0] p, logic keep);
		logic [11:0]             c;
		logic signed [ANG_W-1:0] d;
		logic signed [ANG_W-1:0] h;
		c = (p < 12'd500) ? 12'd500 : ((p > 12'd2500) ? 12'd2500 : p);
		d = 12'sd1500 - $signed(c);
		// truncate toward zero
		h = (d + $signed({{(ANG_W-1){1'b0}}, d[ANG_W-1]})) >>> 1;
		return keep ? h : -h;
	endfunction

	assign base   = {1'b0, leg, 1'b0} + {2'b00, leg};
	assign toe_a  = to_steps(toe_pulse, cfg.dir_mask[base]);
	assign knee_a = to_steps(knee_pulse, cfg.dir_mask[base + 4'd1]);
	assign yaw_a  = to_steps(yaw_pulse, cfg.dir_mask[base + 4'd2]);

	always_comb begin
		case (leg)
			2'd0:    mount = 12'sd750;
			2'd1:    mount = 12'sd250;
			2'd2:    mount = -12'sd750;
			default: mount = -12'sd250;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1.leg  <= leg;
			ang_s1.toe  <= toe_a;
			ang_s1.knee <= knee_a;
			ang_s1.yaw  <= mount + yaw_a;
		end
	end

endmodule

// ----- hdl/lfk_trig.sv -----
// Stage 2: sine and cosine of the three angles from the quarter-wave table.
// Depends on lfk_pkg.
module lfk_trig import lfk_pkg::*; #(
	parameter int SINE_FRAC_BITS = 14
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    valid_s1,
	input  angles_t ang_s1,
	output logic    valid_s2,
	output trig_t   trig_s2
);

	localparam qrom_t QROM = build_qrom(SINE_FRAC_BITS);

	function automatic logic signed [SIN_W-1:0] sine_at(logic signed [12:0] k);
		logic signed [12:0] a;
		logic [8:0]         idx;
		logic               neg;
		if (k < 0)
			a = k + 13'sd2000;
		else if (k >= 13'sd2000)
			a = k - 13'sd2000;
		else
			a = k;
		if (a <= 13'sd500) begin
			idx = a[8:0]; neg = 1'b0;
		end else if (a <= 13'sd1000) begin
			idx = 9'(13'sd1000 - a); neg = 1'b0;
		end else if (a <= 13'sd1500) begin
			idx = 9'(a - 13'sd1000); neg = 1'b1;
		end else begin
			idx = 9'(13'sd2000 - a); neg = 1'b1;
		end
		return neg ? -$signed({1'b0, QROM[idx]}) : $signed({1'b0, QROM[idx]});
	endfunction

	logic signed [12:0] yaw_e, knee_e, toe_e;

	assign yaw_e  = 13'(ang_s1.yaw);
	assign knee_e = 13'(ang_s1.knee);
	assign toe_e  = 13'(ang_s1.toe);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	// cos(k) = sin(k + quarter circle)
	always_ff @(posedge clk) begin
		if (en) begin
			trig_s2.leg <= ang_s1.leg;
			trig_s2.cy  <= sine_at(yaw_e + 13'sd500);
			trig_s2.sy  <= sine_at(yaw_e);
			trig_s2.cp  <= sine_at(knee_e + 13'sd500);
			trig_s2.sp  <= sine_at(knee_e);
			trig_s2.ct  <= sine_at(toe_e + 13'sd500);
			trig_s2.st  <= sine_at(toe_e);
		end
	end

endmodule

// ----- hdl/lfk_mult.sv -----
// Stages 3 and 4: link length times sine and cosine, then the planar
// projection through the yaw sine and cosine. Depends on lfk_pkg.
module lfk_mult import lfk_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_s2,
	input  trig_t trig_s2,
	input  cfg_t  cfg,
	output logic  valid_s4,
	output prod_t prod_s4
);

	logic                    valid_s3;
	logic [1:0]              leg_s3;
	logic signed [SIN_W-1:0] cy_s3, sy_s3;
	logic signed [P1_W-1:0]  lh_cy_s3, lh_sy_s3, lt_cp_s3, lt_sp_s3, ls_ct_s3, ls_st_s3;
	logic signed [13:0]      lh, lt, ls;

	assign lh = $signed({1'b0, cfg.hip_len});
	assign lt = $signed({1'b0, cfg.thigh_len});
	assign ls = $signed({1'b0, cfg.shin_len});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			leg_s3   <= trig_s2.leg;
			cy_s3    <= trig_s2.cy;
			sy_s3    <= trig_s2.sy;
			lh_cy_s3 <= P1_W'(lh * trig_s2.cy);
			lh_sy_s3 <= P1_W'(lh * trig_s2.sy);
			lt_cp_s3 <= P1_W'(lt * trig_s2.cp);
			lt_sp_s3 <= P1_W'(lt * trig_s2.sp);
			ls_ct_s3 <= P1_W'(ls * trig_s2.ct);
			ls_st_s3 <= P1_W'(ls * trig_s2.st);

			prod_s4.leg   <= leg_s3;
			prod_s4.lh_cy <= lh_cy_s3;
			prod_s4.lh_sy <= lh_sy_s3;
			prod_s4.lt_sp <= lt_sp_s3;
			prod_s4.ls_st <= ls_st_s3;
			prod_s4.fx    <= P2_W'(lt_cp_s3 * cy_s3);
			prod_s4.fy    <= P2_W'(lt_cp_s3 * sy_s3);
			prod_s4.tx    <= P2_W'(ls_ct_s3 * cy_s3);
			prod_s4.ty    <= P2_W'(ls_ct_s3 * sy_s3);
		end
	end

endmodule
